FILE: hw/rtl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// shared types, constants and fixed-point helpers for the euler to quaternion block
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int unsigned CordicStepsDef = 30;
  localparam int unsigned FracBitsDef    = 30;
  localparam int unsigned WordW          = 32;
  localparam int unsigned NewtonSteps    = 3;

  typedef struct packed {
    logic signed [WordW-1:0] roll;
    logic signed [WordW-1:0] pitch;
    logic signed [WordW-1:0] yaw;
  } e2q_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] quat_w;
    logic signed [WordW-1:0] quat_x;
    logic signed [WordW-1:0] quat_y;
    logic signed [WordW-1:0] quat_z;
  } e2q_out_t;

  localparam logic [63:0] PiHalfQ62    = 64'h6487ED5110B4611A;
  localparam logic [63:0] PiQuarterQ62 = 64'h3243F6A8885A308D;
  localparam logic [63:0] GainQ30      = 64'h0000_0000_26DD3B6A;

  // round to nearest, ties away from zero, arithmetic right shift by s
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int s);
    logic        neg;
    logic [63:0] m;
    begin
      neg = v[63];
      m   = neg ? 64'(-v) : 64'(v);
      if (s > 0) begin
        m = (m + (64'd1 << (s - 1))) >> s;
      end
      rnd_shift = neg ? -$signed(m) : $signed(m);
    end
  endfunction

  // value with from fraction bits taken to f fraction bits
  function automatic logic signed [63:0] to_frac(input logic signed [63:0] v,
                                                 input int from, input int f);
    begin
      if (from < f) begin
        to_frac = v <<< (f - from);
      end else begin
        to_frac = rnd_shift(v, from - f);
      end
    end
  endfunction

  // atan(2^-i) in q62, alternating series, elaboration time only
  function automatic logic [63:0] atan_q62(input int i);
    logic [63:0] s;
    logic [63:0] term;
    int          e;
    begin
      s = 64'd0;
      if (i == 0) begin
        s = PiQuarterQ62;
      end else begin
        for (int k = 0; k < 32; k++) begin
          e = 62 - i * (2 * k + 1);
          if (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
              s = s - term;
            end else begin
              s = s + term;
            end
          end
        end
      end
      atan_q62 = s;
    end
  endfunction

endpackage

FILE: hw/rtl/euler_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_top
// zyx roll/pitch/yaw to unit attitude quaternion, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input word: start_i with in_i (roll, pitch, yaw, signed q3.29 radians)
//   accepted when start_i is high and busy_o is low; busy_o is always low,
//   so a new word may enter on every clock
//   result word: out_o (quat w, x, y, z, signed q1.30) shown for one cycle
//   with done_o high; the receiver cannot hold results off
// pipeline
//   fold register at the accepting edge, CordicSteps cordic stages (three
//   angles in parallel lanes), then pipelined multipliers: pair and triple
//   products, a register for the four sums, squares, a register for the
//   norm sum, three newton rounds of three chained multiplies, final
//   scaling, output register
//   throughput one word per cycle, set by every stage being registered
// reset
//   rst_ni clears the valid bits only; payload registers are not reset
//   no state survives an item, so reset loses nothing but words in flight
// ----------------------------------------------------------------------------
module euler_to_quaternion_top #(
  parameter int unsigned CordicSteps = e2q_pkg::CordicStepsDef,
  parameter int unsigned FracBits    = e2q_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  e2q_pkg::e2q_in_t  in_i,
  output logic              busy_o,
  output logic              done_o,
  output e2q_pkg::e2q_out_t out_o
);
  import e2q_pkg::*;

  localparam int unsigned DW     = 64;
  localparam int unsigned MulLat = 2;
  // multiply levels: pair, triple, square, 3 x (rr, n2rr, rt), scale
  localparam int unsigned MulLvls = 4 + 3 * NewtonSteps;
  // fold register, then the quaternion sum, norm sum and output registers
  localparam int unsigned Lat     = 1 + CordicSteps + MulLvls * MulLat + 3;

  typedef logic signed [DW-1:0] val_t;

  localparam val_t One    = val_t'(64'sd1 <<< FracBits);
  localparam val_t HalfPi = to_frac($signed(PiHalfQ62), 62, FracBits);
  localparam val_t Gain   = to_frac($signed(GainQ30), 30, FracBits);

  // atan table
  function automatic val_t atan_f(input int i);
    atan_f = to_frac($signed(atan_q62(i)), 62, FracBits);
  endfunction

  // valid chain
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end
  assign busy_o = 1'b0;
  assign done_o = vld_q[Lat-1];

  // ---------------- cordic: three lanes, one stage per step ----------------
  val_t cx_q [3][CordicSteps+1];
  val_t cy_q [3][CordicSteps+1];
  val_t cz_q [3][CordicSteps+1];
  logic fl_q [3][CordicSteps+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [WordW-1:0] raw;
    val_t                    z0;
    assign raw = (l == 0) ? in_i.yaw : (l == 1) ? in_i.pitch : in_i.roll;
    assign z0  = to_frac(val_t'(raw), 30, FracBits);

    always_ff @(posedge clk_i) begin
      cx_q[l][0] <= Gain;
      cy_q[l][0] <= '0;
      if (z0 > HalfPi) begin
        cz_q[l][0] <= z0 - (HalfPi <<< 1);
        fl_q[l][0] <= 1'b1;
      end else if (z0 < -HalfPi) begin
        cz_q[l][0] <= z0 + (HalfPi <<< 1);
        fl_q[l][0] <= 1'b1;
      end else begin
        cz_q[l][0] <= z0;
        fl_q[l][0] <= 1'b0;
      end
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      localparam val_t At = atan_f(i);
      val_t dx, dy;
      assign dx = cy_q[l][i] >>> i;
      assign dy = cx_q[l][i] >>> i;
      always_ff @(posedge clk_i) begin
        fl_q[l][i+1] <= fl_q[l][i];
        if (!cz_q[l][i][DW-1]) begin
          cx_q[l][i+1] <= cx_q[l][i] - dx;
          cy_q[l][i+1] <= cy_q[l][i] + dy;
          cz_q[l][i+1] <= cz_q[l][i] - At;
        end else begin
          cx_q[l][i+1] <= cx_q[l][i] + dx;
          cy_q[l][i+1] <= cy_q[l][i] - dy;
          cz_q[l][i+1] <= cz_q[l][i] + At;
        end
      end
    end
  end

  val_t s1, c1, s2, c2, s3, c3;
  assign s1 = fl_q[0][CordicSteps] ? -cy_q[0][CordicSteps] : cy_q[0][CordicSteps];
  assign c1 = fl_q[0][CordicSteps] ? -cx_q[0][CordicSteps] : cx_q[0][CordicSteps];
  assign s2 = fl_q[1][CordicSteps] ? -cy_q[1][CordicSteps] : cy_q[1][CordicSteps];
  assign c2 = fl_q[1][CordicSteps] ? -cx_q[1][CordicSteps] : cx_q[1][CordicSteps];
  assign s3 = fl_q[2][CordicSteps] ? -cy_q[2][CordicSteps] : cy_q[2][CordicSteps];
  assign c3 = fl_q[2][CordicSteps] ? -cx_q[2][CordicSteps] : cx_q[2][CordicSteps];

  // ---------------- level 1: pair products ----------------
  val_t c1c2, s1s2, s1c2, c1s2;
  val_t s3_d1_q, c3_d1_q, s3_d2_q, c3_d2_q;
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_m_cc (.clk_i, .a_i(c1), .b_i(c2), .p_o(c1c2));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_m_ss (.clk_i, .a_i(s1), .b_i(s2), .p_o(s1s2));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_m_sc (.clk_i, .a_i(s1), .b_i(c2), .p_o(s1c2));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_m_cs (.clk_i, .a_i(c1), .b_i(s2), .p_o(c1s2));
  always_ff @(posedge clk_i) begin
    s3_d1_q <= s3;
    c3_d1_q <= c3;
    s3_d2_q <= s3_d1_q;
    c3_d2_q <= c3_d1_q;
  end

  // ---------------- level 2: triple products ----------------
  val_t t [8];
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t0 (.clk_i, .a_i(s1s2), .b_i(s3_d2_q), .p_o(t[0]));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t1 (.clk_i, .a_i(c1c2), .b_i(c3_d2_q), .p_o(t[1]));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t2 (.clk_i, .a_i(c1c2), .b_i(s3_d2_q), .p_o(t[2]));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t3 (.clk_i, .a_i(s1s2), .b_i(c3_d2_q), .p_o(t[3]));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t4 (.clk_i, .a_i(s1c2), .b_i(s3_d2_q), .p_o(t[4]));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t5 (.clk_i, .a_i(c1s2), .b_i(c3_d2_q), .p_o(t[5]));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t6 (.clk_i, .a_i(s1c2), .b_i(c3_d2_q), .p_o(t[6]));
  e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_t7 (.clk_i, .a_i(c1s2), .b_i(s3_d2_q), .p_o(t[7]));

  val_t q_q [4];
  always_ff @(posedge clk_i) begin
    q_q[0] <= t[0] + t[1];
    q_q[1] <= t[2] - t[3];
    q_q[2] <= t[4] + t[5];
    q_q[3] <= t[6] - t[7];
  end

  // quaternion delay line to the final scaling: squares, norm sum, newton
  localparam int unsigned QDly = MulLat * (1 + 3 * NewtonSteps) + 1;
  val_t qd_q [QDly+1][4];
  always_comb qd_q[0] = q_q;
  for (genvar d = 0; d < QDly; d++) begin : g_qd
    always_ff @(posedge clk_i) qd_q[d+1] <= qd_q[d];
  end

  // ---------------- level 3: norm squared ----------------
  val_t sq [4];
  for (genvar k = 0; k < 4; k++) begin : g_sq
    e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_sq (.clk_i, .a_i(q_q[k]), .b_i(q_q[k]),
                                                    .p_o(sq[k]));
  end
  val_t n2_q;
  always_ff @(posedge clk_i) n2_q <= sq[0] + sq[1] + sq[2] + sq[3];

  // ---------------- newton rounds ----------------
  val_t rr [NewtonSteps+1];
  val_t n2n [NewtonSteps+1];
  assign rr[0]  = One;
  assign n2n[0] = n2_q;
  for (genvar n = 0; n < NewtonSteps; n++) begin : g_nt
    val_t r2, n2rr, rt;
    val_t r_d1_q, r_d2_q, r_d3_q, r_d4_q, n_d1_q, n_d2_q;
    val_t n_d3_q, n_d4_q, n_d5_q, n_d6_q;
    val_t tt;
    e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_rr (.clk_i, .a_i(rr[n]), .b_i(rr[n]), .p_o(r2));
    always_ff @(posedge clk_i) begin
      r_d1_q <= rr[n];  r_d2_q <= r_d1_q; r_d3_q <= r_d2_q; r_d4_q <= r_d3_q;
      n_d1_q <= n2n[n]; n_d2_q <= n_d1_q; n_d3_q <= n_d2_q; n_d4_q <= n_d3_q;
      n_d5_q <= n_d4_q; n_d6_q <= n_d5_q;
    end
    e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_nr (.clk_i, .a_i(n_d2_q), .b_i(r2),
                                                    .p_o(n2rr));
    assign tt = (One + (One <<< 1)) - n2rr;
    e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_rt (.clk_i, .a_i(r_d4_q), .b_i(tt), .p_o(rt));
    assign rr[n+1]  = rnd_shift(rt, 1);
    assign n2n[n+1] = n_d6_q;
  end

  // ---------------- final scaling and output ----------------
  val_t fq [4];
  logic signed [WordW-1:0] oq [4];
  localparam val_t Lim = val_t'(64'sd1 <<< 30);
  for (genvar k = 0; k < 4; k++) begin : g_out
    val_t v;
    e2q_mul #(.FracBits(FracBits), .DataW(DW)) u_sc (.clk_i, .a_i(qd_q[QDly][k]),
                                                    .b_i(rr[NewtonSteps]), .p_o(fq[k]));
    always_comb begin
      v = to_frac(fq[k], FracBits, 30);
      if (v > Lim) v = Lim;
      if (v < -Lim) v = -Lim;
    end
    always_ff @(posedge clk_i) oq[k] <= v[WordW-1:0];
  end

  assign out_o.quat_w = oq[0];
  assign out_o.quat_x = oq[1];
  assign out_o.quat_y = oq[2];
  assign out_o.quat_z = oq[3];

  // ---------------- checks ----------------
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result without input");
  a_start_gives_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##(Lat-1) done_o)
    else $error("input lost in pipeline");
  a_w_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.quat_w <= 32'sh4000_0000 && out_o.quat_w >= -32'sh4000_0000))
    else $error("w out of range");

endmodule

FILE: hw/rtl/e2q_mul.sv
// ----------------------------------------------------------------------------
// e2q_mul
// pipelined signed fixed-point multiply, exact product rounded to q(f)
// magnitude product split into 32x32 partial products over two stages
// ----------------------------------------------------------------------------
module e2q_mul #(
  parameter int unsigned FracBits = e2q_pkg::FracBitsDef,
  parameter int unsigned DataW    = 64
) (
  input  logic                    clk_i,
  input  logic signed [DataW-1:0] a_i,
  input  logic signed [DataW-1:0] b_i,
  output logic signed [DataW-1:0] p_o
);
  import e2q_pkg::*;

  logic                    neg_q, neg2_q;
  logic [63:0]             ua, ub;
  logic [63:0]             p00_q, p01_q, p10_q, p11_q;
  logic [127:0]            full;
  logic [127:0]            prod_q;
  logic [127:0]            rnd;

  assign ua = a_i[DataW-1] ? 64'(-a_i) : 64'(a_i);
  assign ub = b_i[DataW-1] ? 64'(-b_i) : 64'(b_i);

  always_ff @(posedge clk_i) begin
    neg_q <= a_i[DataW-1] ^ b_i[DataW-1];
    p00_q <= ua[31:0] * ub[31:0];
    p01_q <= ua[31:0] * ub[63:32];
    p10_q <= ua[63:32] * ub[31:0];
    p11_q <= ua[63:32] * ub[63:32];
  end

  assign full = {64'd0, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32)
              + ({p11_q, 64'd0});

  always_ff @(posedge clk_i) begin
    neg2_q <= neg_q;
    prod_q <= full;
  end

  always_comb begin
    rnd = (prod_q + (128'd1 << (FracBits - 1))) >> FracBits;
    p_o = neg2_q ? -$signed(rnd[DataW-1:0]) : $signed(rnd[DataW-1:0]);
  end

endmodule
